>>> hdl/sssg_pkg.sv
// ----------------------------------------------------------------------------
// sssg_pkg: shared types and constants for the sensor sample generator
// Generator constants, sentinels and the shared multiplier's operation codes.
// ----------------------------------------------------------------------------
package sssg_pkg;

  // LCG noise generator
  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_INC    = 32'd1013904223;
  localparam logic [31:0] NOISE_SEED = 32'hDEADBEEF;

  // floor(n / 100) = (n * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit n
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
  localparam int          DIV100_SHIFT = 37;
  localparam int          QUOT_W       = 26;

  // Triangle wave
  localparam logic [6:0]  PHASE_PERIOD = 7'd63;
  localparam logic [10:0] TEMP_STEP    = 11'(600 / 31);
  localparam logic [10:0] TEMP_LOW     = 11'd200;
  localparam logic [10:0] TEMP_HIGH    = 11'd800;

  // Accelerometer scaling
  localparam logic [16:0] NOISE_FULL = 17'd65535;
  localparam logic [9:0]  Z_CENTER   = 10'd980;
  localparam logic [9:0]  LAT_OFFSET = 10'd100;

  // Failure sentinels
  localparam logic [10:0] SENT_TEMP  = 11'd1550;
  localparam logic [9:0]  SENT_ACCEL = 10'd420;

  // Operations of the shared multiplier
  typedef enum logic {
    MUL_DIV100,
    MUL_LCG
  } mul_op_t;

endpackage

>>> hdl/sssg_mult.sv
// ----------------------------------------------------------------------------
// sssg_mult: shared 32x32 multiplier
// Either the time-by-reciprocal product or the LCG state-by-multiplier product.
// ----------------------------------------------------------------------------
module sssg_mult (
  input  sssg_pkg::mul_op_t op,
  input  logic [31:0]       time_val,
  input  logic [31:0]       noise_val,
  output logic [63:0]       product
);

  logic [31:0] opa;
  logic [31:0] opb;

  always_comb begin
    case (op)
      sssg_pkg::MUL_DIV100: begin
        opa = time_val;
        opb = sssg_pkg::DIV100_MAGIC;
      end
      sssg_pkg::MUL_LCG: begin
        opa = noise_val;
        opb = sssg_pkg::LCG_MUL;
      end
      default: begin
        opa = noise_val;
        opb = sssg_pkg::LCG_MUL;
      end
    endcase
  end

  assign product = {32'd0, opa} * {32'd0, opb};

endmodule

>>> hdl/sssg_scale.sv
// ----------------------------------------------------------------------------
// sssg_scale: noise draw to accelerometer units
// Lateral axes: floor(v*200/65535) - 100. Vertical axis: 960 + floor(v*40/65535).
// ----------------------------------------------------------------------------
module sssg_scale (
  input  logic [15:0]        noise_v,
  output logic signed [9:0]  lateral,
  output logic [9:0]         vertical
);

  // floor(x / 65535) for x below 2^24: x>>16 plus one correction step
  function automatic logic [7:0] div_full(input logic [23:0] x);
    logic [7:0]  q0;
    logic [16:0] r;
    begin
      q0 = x[23:16];
      r  = {1'b0, x[15:0]} + {9'd0, q0};
      if (r >= sssg_pkg::NOISE_FULL) begin
        div_full = q0 + 8'd1;
      end else begin
        div_full = q0;
      end
    end
  endfunction

  logic [23:0] v200;
  logic [23:0] v40;
  logic [7:0]  lat_q;
  logic [7:0]  vert_q;

  // constant products as shift-adds
  assign v200 = {1'b0, noise_v, 7'd0} + {2'd0, noise_v, 6'd0} + {5'd0, noise_v, 3'd0};
  assign v40  = {3'd0, noise_v, 5'd0} + {5'd0, noise_v, 3'd0};

  assign lat_q  = div_full(v200);
  assign vert_q = div_full(v40);

  assign lateral  = signed'({2'd0, lat_q} - sssg_pkg::LAT_OFFSET);
  assign vertical = sssg_pkg::Z_CENTER - 10'd20 + {2'd0, vert_q};

endmodule

>>> hdl/sssg_temp.sv
// ----------------------------------------------------------------------------
// sssg_temp: triangle-wave temperature
// Phase = quotient mod 63 by 6-bit digit folding (64 = 1 mod 63).
// ----------------------------------------------------------------------------
module sssg_temp (
  input  logic [sssg_pkg::QUOT_W-1:0] quot,
  output logic [10:0]                 temp
);

  logic [8:0]  dsum;
  logic [6:0]  fold;
  logic [5:0]  phase;
  logic [10:0] ramp;

  assign dsum = {3'd0, quot[5:0]} + {3'd0, quot[11:6]} + {3'd0, quot[17:12]}
              + {3'd0, quot[23:18]} + {7'd0, quot[25:24]};
  assign fold = {4'd0, dsum[8:6]} + {1'b0, dsum[5:0]};

  always_comb begin
    if (fold >= sssg_pkg::PHASE_PERIOD) begin
      phase = 6'(fold - sssg_pkg::PHASE_PERIOD);
    end else begin
      phase = fold[5:0];
    end
  end

  // phase[4:0] is the offset into either half of the wave
  assign ramp = sssg_pkg::TEMP_STEP * {6'd0, phase[4:0]};

  always_comb begin
    if (!phase[5]) begin
      temp = sssg_pkg::TEMP_LOW + ramp;
    end else begin
      temp = sssg_pkg::TEMP_HIGH - ramp;
    end
  end

endmodule

>>> hdl/synthetic_sensor_sample_generator_unit.sv
// ----------------------------------------------------------------------------
// synthetic_sensor_sample_generator_unit: simulated sensor record generator
// Flow: an input beat leads through the DIV, X, Y and Z passes to FIN (fault
//   mode goes straight to FIN), where the record is loaded and out_valid rises.
//   in_ready is low until the sequencer is back in idle, which covers the four
//   passes of the shared multiplier; a stalled output register holds it in FIN.
// Reset: synchronous; noise state back to 0xDEADBEEF, fault_mode cleared.
// ----------------------------------------------------------------------------
module synthetic_sensor_sample_generator_unit (
  input  logic               clk,
  input  logic               rst,
  // configuration: fault_mode
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  // sample tick
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        time_ms,
  // sensor record
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        rec_time_ms,
  output logic [10:0]        temperature_x10,
  output logic signed [9:0]  accel_x_cg,
  output logic signed [9:0]  accel_y_cg,
  output logic [9:0]         accel_z_cg
);

  // Sequencer passes:
  //   DIV  : multiplier forms time * 1/100, quotient kept
  //   X    : first LCG step
  //   Y    : second LCG step, first draw scaled to x
  //   Z    : third LCG step, second draw scaled to y
  //   FIN  : third draw scaled to z, temperature formed, record loaded
  //          into the output register once that register is free
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_X,
    ST_Y,
    ST_Z,
    ST_FIN
  } state_t;

  state_t state;

  logic                        fault_mode;
  logic                        fault_item;  // fault_mode as seen at the beat
  logic [31:0]                 time_reg;
  logic [31:0]                 noise;
  logic [sssg_pkg::QUOT_W-1:0] quot;
  logic signed [9:0]           ax;
  logic signed [9:0]           ay;

  sssg_pkg::mul_op_t mul_op;
  logic [63:0]       product;
  logic [31:0]       noise_next;
  logic signed [9:0] lateral;
  logic [9:0]        vertical;
  logic [10:0]       temp;
  logic              out_free;
  logic              load_rec;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign load_rec = (state == ST_FIN) && out_free;

  assign mul_op = (state == ST_DIV) ? sssg_pkg::MUL_DIV100 : sssg_pkg::MUL_LCG;

  sssg_mult u_mult (
    .op        (mul_op),
    .time_val  (time_reg),
    .noise_val (noise),
    .product   (product)
  );

  assign noise_next = product[31:0] + sssg_pkg::LCG_INC;

  // the scaler always looks at the most recent draw held in noise
  sssg_scale u_scale (
    .noise_v  (noise[15:0]),
    .lateral  (lateral),
    .vertical (vertical)
  );

  sssg_temp u_temp (
    .quot (quot),
    .temp (temp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fault_mode <= 1'b0;
      noise      <= sssg_pkg::NOISE_SEED;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        fault_mode <= cfg_wdata;
      end

      // output beat taken unless a new record replaces it this cycle
      if (load_rec) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            time_reg   <= time_ms;
            fault_item <= fault_mode;
            // fault mode skips the generator entirely
            state      <= fault_mode ? ST_FIN : ST_DIV;
          end
        end
        ST_DIV: begin
          quot  <= product[sssg_pkg::DIV100_SHIFT+sssg_pkg::QUOT_W-1:sssg_pkg::DIV100_SHIFT];
          state <= ST_X;
        end
        ST_X: begin
          noise <= noise_next;
          state <= ST_Y;
        end
        ST_Y: begin
          noise <= noise_next;
          ax    <= lateral;
          state <= ST_Z;
        end
        ST_Z: begin
          noise <= noise_next;
          ay    <= lateral;
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            rec_time_ms <= time_reg;
            if (fault_item) begin
              temperature_x10 <= sssg_pkg::SENT_TEMP;
              accel_x_cg      <= signed'(sssg_pkg::SENT_ACCEL);
              accel_y_cg      <= signed'(sssg_pkg::SENT_ACCEL);
              accel_z_cg      <= sssg_pkg::SENT_ACCEL;
            end else begin
              temperature_x10 <= temp;
              accel_x_cg      <= ax;
              accel_y_cg      <= ay;
              accel_z_cg      <= vertical;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/sssg_checker.sv
// ----------------------------------------------------------------------------
// sssg_checker: port-level checks for the sensor sample generator
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module sssg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [31:0]        rec_time_ms,
  input logic [10:0]        temperature_x10,
  input logic signed [9:0]  accel_x_cg,
  input logic signed [9:0]  accel_y_cg,
  input logic [9:0]         accel_z_cg
);

  // one sample in flight: an accepted beat makes the block busy
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an input beat");

  // stalled record holds: time, temperature and z stay put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(rec_time_ms)
      && $stable(temperature_x10) && $stable(accel_z_cg)))
    else $error("stalled record changed");

  // sentinels appear on all four sensor fields together or not at all
  a_sentinel_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((temperature_x10 == 11'd1550) == (accel_z_cg == 10'd420))
      && ((temperature_x10 == 11'd1550) == (accel_x_cg == 10'sd420))
      && ((temperature_x10 == 11'd1550) == (accel_y_cg == 10'sd420))))
    else $error("partial sentinel record");

  // temperature stays on the wave or is the sentinel
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((temperature_x10 >= 11'd200 && temperature_x10 <= 11'd800)
      || temperature_x10 == 11'd1550))
    else $error("temperature out of range");

endmodule

bind synthetic_sensor_sample_generator_unit sssg_checker u_sssg_checker (.*);
